// File: rtl/rgblab_pkg.sv
// ----------------------------------------------------------------------------
// rgblab_pkg
// shared constants, gamma table builder and coefficient set for the
// bgra to cielab pixel converter
// ----------------------------------------------------------------------------
package rgblab_pkg;

	localparam int ChanW   = 8;
	localparam int LinW    = 16;
	localparam int ProdW   = 32;
	localparam int TriW    = 33;
	localparam int RootW   = 21;
	localparam int RootSq  = 2 * RootW;
	localparam int RemW    = 64;
	localparam int FW      = 22;
	localparam int RawW    = 34;
	localparam int LW      = 15;
	localparam int AbW     = 16;
	localparam int Lq      = 30;
	localparam int FFrac   = 20;
	localparam int RndSh   = FFrac - 8;

	localparam logic [ChanW-1:0] CHAN_MASK  = 8'hFF;
	localparam logic [TriW-1:0]  THRESH_Q32 = 33'd38036230;
	localparam logic [18:0]      SLOPE_Q16  = 19'd510329;
	localparam logic [FW-1:0]    OFFSET_Q20 = 22'd144631;
	localparam logic [LinW-1:0]  LIN_ONE    = 16'hFFFF;
	localparam int unsigned      GAMMA_NUM  = 563;
	localparam int               L_MAX      = 25600;
	localparam int               S16_MIN    = -32768;
	localparam int               S16_MAX    = 32767;

	typedef logic [LinW-1:0] coef_row_t [3];
	typedef coef_row_t coef_t [3];
	localparam coef_t COEF = '{
		'{16'd39762, 16'd12794, 16'd12976},
		'{16'd19489, 16'd41114, 16'd4950},
		'{16'd1627,  16'd4255,  16'd59654}
	};

	typedef logic [LinW-1:0] gamma_rom_t [256];

	function automatic longint unsigned isqrt64(input longint unsigned n_in);
		longint unsigned n;
		longint unsigned r;
		longint unsigned bt;
		n  = n_in;
		r  = 0;
		bt = 64'd1 << 62;
		while (bt > n) bt = bt >> 2;
		while (bt != 0) begin
			if (n >= r + bt) begin
				n = n - (r + bt);
				r = (r >> 1) + bt;
			end else begin
				r = r >> 1;
			end
			bt = bt >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned log2_q30(input int unsigned v);
		int unsigned e;
		longint unsigned m;
		longint unsigned res;
		e = 0;
		while (e < 31 && (v >> (e + 1)) != 0) e++;
		m   = longint'(v) << (Lq - e);
		res = longint'(e) << Lq;
		for (int k = Lq - 1; k >= 0; k--) begin
			m = (m * m) >> Lq;
			if (m >= (64'd2 << Lq)) begin
				m   = m >> 1;
				res = res | (64'd1 << k);
			end
		end
		return res;
	endfunction

	// evaluated at elaboration only
	function automatic gamma_rom_t build_gamma();
		gamma_rom_t      rom;
		longint unsigned root [Lq];
		longint unsigned l255;
		longint unsigned d;
		longint unsigned e;
		longint unsigned ip;
		longint unsigned fr;
		longint unsigned p;
		int unsigned     s;
		l255 = log2_q30(255);
		root[Lq-1] = isqrt64(64'd1 << (2 * Lq - 1));
		for (int j = Lq - 1; j > 0; j--) root[j-1] = isqrt64(root[j] << Lq);
		rom[0]   = '0;
		rom[255] = LIN_ONE;
		for (int v = 1; v < 255; v++) begin
			d  = l255 - log2_q30(v);
			e  = (d * GAMMA_NUM + 128) >> 8;
			ip = e >> Lq;
			fr = e & ((64'd1 << Lq) - 1);
			p  = 64'd1 << Lq;
			if (ip > 17) begin
				rom[v] = '0;
			end else begin
				for (int j = 0; j < Lq; j++)
					if (((fr >> j) & 1) != 0) p = (p * root[j]) >> Lq;
				s = 14 + int'(ip);
				p = (p + (64'd1 << (s - 1))) >> s;
				rom[v] = (p > 65535) ? LIN_ONE : p[LinW-1:0];
			end
		end
		return rom;
	endfunction

	localparam gamma_rom_t GAMMA_ROM = build_gamma();

endpackage

// File: rtl/rgb_to_cielab_pixel.sv
// ----------------------------------------------------------------------------
// rgb_to_cielab_pixel
// bgra pixel word to cielab (d65), gamma rom, 3x3 matrix, cube root
// pipeline and saturating l/a/b output
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  in      | in_valid, in_stall, pixel_word           | beat in
//  out     | out_valid, out_stall, lightness,         | beat out
//          | green_red, blue_yellow                   |
//
//  one beat per clock while no stalled output beat holds the pipeline
//  latency is set by the cube root, one root bit per stage over 21 stages
//  arst_n clears all valid bits, payload registers are not reset
//  a stalled output beat freezes the whole pipeline, in_stall follows it
module rgb_to_cielab_pixel (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [31:0]                 pixel_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [rgblab_pkg::LW-1:0]   lightness,
	output logic signed [rgblab_pkg::AbW-1:0] green_red,
	output logic signed [rgblab_pkg::AbW-1:0] blue_yellow
);
	import rgblab_pkg::*;

	localparam int CR = RootW;

	logic en;
	assign in_stall = out_valid & out_stall;
	assign en = ~in_stall;

	// stage 1: gamma lookup
	logic            v_s1;
	logic [LinW-1:0] lin_s1 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			lin_s1[0] <= GAMMA_ROM[pixel_word[23:16] & CHAN_MASK];
			lin_s1[1] <= GAMMA_ROM[pixel_word[15:8] & CHAN_MASK];
			lin_s1[2] <= GAMMA_ROM[pixel_word[7:0] & CHAN_MASK];
		end
	end

	// stage 2: matrix products
	logic             v_s2;
	logic [ProdW-1:0] prod_s2 [3][3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					prod_s2[i][j] <= lin_s1[j] * COEF[i][j];
		end
	end

	// stage 3: x, y, z sums in q0.32
	logic            v_s3;
	logic [TriW-1:0] t_s3 [3];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				t_s3[i] <= TriW'(prod_s2[i][0]) + TriW'(prod_s2[i][1])
					+ TriW'(prod_s2[i][2]);
		end
	end

	// root pipeline, index 0 is loaded from the sums
	logic                cv_s [CR+1];
	logic [RemW-1:0]     rem_s [CR+1][3];
	logic [RootW-1:0]    root_s [CR+1][3];
	logic [RootSq-1:0]   rsq_s [CR+1][3];
	logic [FW-1:0]       linf_s [CR+1][3];
	logic                islin_s [CR+1][3];

	logic [TriW+18:0] slope_prod [3];
	always_comb begin
		for (int i = 0; i < 3; i++) slope_prod[i] = t_s3[i] * SLOPE_Q16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cv_s[0] <= 1'b0;
		else if (en) cv_s[0] <= v_s3;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i]   <= RemW'(t_s3[i]) << (3 * FFrac - 32);
				root_s[0][i]  <= '0;
				rsq_s[0][i]   <= '0;
				linf_s[0][i]  <= FW'(slope_prod[i] >> 28) + OFFSET_Q20;
				islin_s[0][i] <= (t_s3[i] <= THRESH_Q32);
			end
		end
	end

	for (genvar k = 0; k < CR; k++) begin : g_root
		localparam int B = FFrac - k;
		logic [RemW+1:0] delta [3];
		logic            take  [3];
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				// (r + 2^b)^3 - r^3
				delta[i] = ((RemW+2)'(rsq_s[k][i]) * 3 << B)
					+ ((RemW+2)'(root_s[k][i]) * 3 << (2 * B))
					+ ((RemW+2)'(1) << (3 * B));
				take[i] = delta[i] <= (RemW+2)'(rem_s[k][i]);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cv_s[k+1] <= 1'b0;
			else if (en) cv_s[k+1] <= cv_s[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					linf_s[k+1][i]  <= linf_s[k][i];
					islin_s[k+1][i] <= islin_s[k][i];
					if (take[i]) begin
						rem_s[k+1][i]  <= rem_s[k][i] - delta[i][RemW-1:0];
						root_s[k+1][i] <= root_s[k][i] | (RootW'(1) << B);
						rsq_s[k+1][i]  <= rsq_s[k][i]
							+ (RootSq'(root_s[k][i]) << (B + 1))
							+ (RootSq'(1) << (2 * B));
					end else begin
						rem_s[k+1][i]  <= rem_s[k][i];
						root_s[k+1][i] <= root_s[k][i];
						rsq_s[k+1][i]  <= rsq_s[k][i];
					end
				end
			end
		end
	end

	// scale stage: l, a, b in q.20
	logic [FW-1:0] fsel [3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			fsel[i] = islin_s[CR][i] ? linf_s[CR][i] : FW'(root_s[CR][i]);
	end

	logic                   v_sc;
	logic signed [RawW-1:0] lraw_sc;
	logic signed [RawW-1:0] araw_sc;
	logic signed [RawW-1:0] braw_sc;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_sc <= 1'b0;
		else if (en) v_sc <= cv_s[CR];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			lraw_sc <= RawW'(116) * $signed({1'b0, fsel[1]})
				- (RawW'(16) <<< FFrac);
			araw_sc <= RawW'(500)
				* ($signed(RawW'(fsel[0])) - $signed(RawW'(fsel[1])));
			braw_sc <= RawW'(200)
				* ($signed(RawW'(fsel[1])) - $signed(RawW'(fsel[2])));
		end
	end

	// round half away from zero, then saturate
	function automatic logic signed [RawW-1:0] rnd(input logic signed [RawW-1:0] x);
		logic signed [RawW-1:0] h;
		h = RawW'(1) <<< (RndSh - 1);
		if (x >= 0) return (x + h) >>> RndSh;
		return -((-x + h) >>> RndSh);
	endfunction

	logic signed [RawW-1:0] lr, ar, br;
	logic [LW-1:0]          lsat;
	logic signed [AbW-1:0]  asat, bsat;
	always_comb begin
		lr = rnd(lraw_sc);
		ar = rnd(araw_sc);
		br = rnd(braw_sc);
		if (lr < 0) lsat = '0;
		else if (lr > RawW'(L_MAX)) lsat = LW'(L_MAX);
		else lsat = lr[LW-1:0];
		if (ar < RawW'(S16_MIN)) asat = AbW'(S16_MIN);
		else if (ar > RawW'(S16_MAX)) asat = AbW'(S16_MAX);
		else asat = ar[AbW-1:0];
		if (br < RawW'(S16_MIN)) bsat = AbW'(S16_MIN);
		else if (br > RawW'(S16_MAX)) bsat = AbW'(S16_MAX);
		else bsat = br[AbW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_sc;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			lightness   <= lsat;
			green_red   <= asat;
			blue_yellow <= bsat;
		end
	end

endmodule

// File: rtl/rgblab_checker.sv
// ----------------------------------------------------------------------------
// rgblab_checker
// port level checks for the cielab pixel converter
// ----------------------------------------------------------------------------
module rgblab_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [rgblab_pkg::LW-1:0]         lightness,
	input logic signed [rgblab_pkg::AbW-1:0] green_red,
	input logic signed [rgblab_pkg::AbW-1:0] blue_yellow
);
	import rgblab_pkg::*;

	// a waiting output beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(lightness)
			&& $stable(green_red) && $stable(blue_yellow))
		else $error("stalled output beat changed");

	// input is only held back by a blocked output
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output free");

	a_l_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> lightness <= LW'(L_MAX))
		else $error("lightness out of range");

endmodule

bind rgb_to_cielab_pixel rgblab_checker u_rgblab_checker (.*);
